>>> sv/scw_pkg.sv
// ----------------------------------------------------------------------------
// scw_pkg
// Shared types, codes and arithmetic helpers for the congestion window keeper.
// ----------------------------------------------------------------------------
package scw_pkg;

  // Width of the window, threshold, in-flight and partial-acked registers
  localparam int unsigned WinBits    = 32;
  localparam int unsigned MtuBits    = 16;
  localparam int unsigned BytesBits  = 20;
  localparam int unsigned TsnBits    = 32;

  // Event queue between the decoder and the execution stage
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

  // Stream packing
  localparam int unsigned InDataBits  = 56;
  localparam int unsigned OutDataBits = 136;
  localparam int unsigned CmdBits     = 3;
  localparam int unsigned ErrBits     = 3;

  localparam logic [MtuBits-1:0] ResetMtu      = 16'd1500;
  localparam logic [WinBits-1:0] InitWindowCap = 32'd4380;

  typedef enum logic [CmdBits-1:0] {
    CMD_ACK     = 3'd0,
    CMD_TX      = 3'd1,
    CMD_ENTER   = 3'd2,
    CMD_EXIT    = 3'd3,
    CMD_IDLE    = 3'd4,
    CMD_RTO     = 3'd5,
    CMD_RESTART = 3'd6,
    CMD_QUERY   = 3'd7
  } cmd_e;

  typedef enum logic [ErrBits-1:0] {
    ERR_NONE          = 3'd0,
    ERR_EXCEEDS_WIN   = 3'd1,
    ERR_RECOVERING    = 3'd2,
    ERR_NOT_RECOVERING = 3'd3,
    ERR_IDLE_BUSY     = 3'd4
  } err_e;

  // One decoded event as it travels through the queue
  typedef struct packed {
    cmd_e                 cmd;
    logic [BytesBits-1:0] bytes;
    logic [MtuBits-1:0]   bytes_capped;  // min(bytes, path MTU)
    logic                 advanced;
    logic                 pending;
    logic [TsnBits-1:0]   exit_tsn;
  } event_t;

  function automatic logic [WinBits-1:0] sat_add(input logic [WinBits-1:0] a,
                                                 input logic [WinBits-1:0] b);
    logic [WinBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WinBits] ? {WinBits{1'b1}} : s[WinBits-1:0];
  endfunction

  function automatic logic [WinBits-1:0] umax(input logic [WinBits-1:0] a,
                                              input logic [WinBits-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [WinBits-1:0] umin(input logic [WinBits-1:0] a,
                                              input logic [WinBits-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // min(4*MTU, max(2*MTU, cap)); 4*MTU always fits the window width
  function automatic logic [WinBits-1:0] start_window(input logic [MtuBits-1:0] mtu);
    logic [WinBits-1:0] m;
    m = WinBits'(mtu);
    return umin(m << 2, umax(m << 1, InitWindowCap));
  endfunction

endpackage

>>> sv/scw_front.sv
// ----------------------------------------------------------------------------
// scw_front
// Unpacks an incoming stream item and classifies it into an event record.
// ----------------------------------------------------------------------------
module scw_front (
  input  logic [scw_pkg::CmdBits-1:0]    cmd_i,
  input  logic [scw_pkg::InDataBits-1:0] data_i,
  input  logic [scw_pkg::MtuBits-1:0]    mtu_i,
  output scw_pkg::event_t                evt_o
);
  import scw_pkg::*;

  logic [BytesBits-1:0] bytes;

  assign bytes = data_i[BytesBits-1:0];

  always_comb begin
    evt_o.cmd      = cmd_e'(cmd_i);
    evt_o.bytes    = bytes;
    evt_o.advanced = data_i[BytesBits];
    evt_o.pending  = data_i[BytesBits+1];
    evt_o.exit_tsn = data_i[BytesBits+2 +: TsnBits];
    // cap the slow start increment here, off the execution path
    if (bytes < BytesBits'(mtu_i)) begin
      evt_o.bytes_capped = bytes[MtuBits-1:0];
    end else begin
      evt_o.bytes_capped = mtu_i;
    end
  end

endmodule

>>> sv/scw_queue.sv
// ----------------------------------------------------------------------------
// scw_queue
// Short event queue that decouples the decoder from the execution stage.
// ----------------------------------------------------------------------------
module scw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scw_pkg::event_t push_evt_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output scw_pkg::event_t pop_evt_o
);
  import scw_pkg::*;

  event_t               entry_q [QueueDepth];
  logic [QPtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntBits-1:0]  count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o    = (count_q == QCntBits'(QueueDepth));
  assign valid_o   = (count_q != '0);
  assign pop_evt_o = entry_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_evt_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntBits'(QueueDepth))
    else $error("event queue count beyond depth");
`endif

endmodule

>>> sv/scw_back.sv
// ----------------------------------------------------------------------------
// scw_back
// Executes queued events against the window state and registers the result.
// ----------------------------------------------------------------------------
module scw_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [scw_pkg::MtuBits-1:0]     mtu_i,
  input  logic                            evt_valid_i,
  input  scw_pkg::event_t                 evt_i,
  output logic                            evt_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [scw_pkg::OutDataBits-1:0] out_data_o,
  output logic [scw_pkg::ErrBits-1:0]     out_err_o
);
  import scw_pkg::*;

  logic [WinBits-1:0] window_q, window_d;
  logic [WinBits-1:0] thresh_q, thresh_d;
  logic [WinBits-1:0] inflight_q, inflight_d;
  logic [WinBits-1:0] partial_q, partial_d;
  logic               recov_q, recov_d;
  logic [TsnBits-1:0] exit_q, exit_d;

  logic               out_valid_q;
  logic [OutDataBits-1:0] out_data_q;
  err_e               out_err_q;

  logic               exec;
  logic               fits;
  err_e               err;
  logic [WinBits-1:0] bytes_w, mtu_w, mtu4_w, halved, pa_sum;

  assign evt_pop_o = exec;
  assign exec      = evt_valid_i && (!out_valid_q || out_ready_i);
  assign bytes_w   = WinBits'(evt_i.bytes);
  assign mtu_w     = WinBits'(mtu_i);
  assign mtu4_w    = mtu_w << 2;
  assign halved    = umax(window_q >> 1, mtu4_w);
  assign pa_sum    = sat_add(partial_q, bytes_w);
  assign fits      = (inflight_q <= window_q) && (bytes_w <= (window_q - inflight_q));

  always_comb begin
    window_d   = window_q;
    thresh_d   = thresh_q;
    inflight_d = inflight_q;
    partial_d  = partial_q;
    recov_d    = recov_q;
    exit_d     = exit_q;
    err        = ERR_NONE;
    if (exec) begin
      unique case (evt_i.cmd)
        CMD_ACK: begin
          inflight_d = inflight_q - umin(inflight_q, bytes_w);
          if (evt_i.advanced) begin
            if (window_q <= thresh_q) begin
              if (!recov_q && evt_i.pending) begin
                window_d = sat_add(window_q, WinBits'(evt_i.bytes_capped));
              end
            end else begin
              partial_d = pa_sum;
              if ((pa_sum >= window_q) && evt_i.pending) begin
                partial_d = pa_sum - window_q;
                window_d  = sat_add(window_q, mtu_w);
              end
            end
          end
        end
        CMD_TX: begin
          if (!fits) begin
            err = ERR_EXCEEDS_WIN;
          end else begin
            inflight_d = sat_add(inflight_q, bytes_w);
          end
        end
        CMD_ENTER: begin
          if (recov_q) begin
            err = ERR_RECOVERING;
          end else begin
            recov_d   = 1'b1;
            exit_d    = evt_i.exit_tsn;
            thresh_d  = halved;
            window_d  = halved;
            partial_d = '0;
          end
        end
        CMD_EXIT: begin
          if (!recov_q) begin
            err = ERR_NOT_RECOVERING;
          end else begin
            recov_d = 1'b0;
          end
        end
        CMD_IDLE: begin
          if (inflight_q != '0) begin
            err = ERR_IDLE_BUSY;
          end else begin
            window_d  = start_window(mtu_i);
            partial_d = '0;
          end
        end
        CMD_RTO: begin
          thresh_d   = halved;
          window_d   = mtu_w;
          inflight_d = '0;
        end
        CMD_RESTART: begin
          thresh_d   = mtu4_w;
          window_d   = start_window(mtu_i);
          inflight_d = '0;
          partial_d  = '0;
          recov_d    = 1'b0;
        end
        CMD_QUERY: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= InitWindowCap;
      thresh_q    <= WinBits'(ResetMtu) << 2;
      inflight_q  <= '0;
      partial_q   <= '0;
      recov_q     <= 1'b0;
      exit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      window_q   <= window_d;
      thresh_q   <= thresh_d;
      inflight_q <= inflight_d;
      partial_q  <= partial_d;
      recov_q    <= recov_d;
      exit_q     <= exit_d;
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_data_q <= {6'b0, exit_d[31:0], recov_d, inflight_d[31:0],
                     thresh_d[31:0], window_d[31:0], fits};
      out_err_q  <= err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_err_o   = out_err_q;

`ifndef ASSERT_OFF
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && err != ERR_NONE) |=> ($stable(window_q) && $stable(thresh_q) &&
      $stable(inflight_q) && $stable(partial_q) && $stable(recov_q) && $stable(exit_q)))
    else $error("rejected event changed state");
`endif

`ifndef ASSERT_OFF
  a_recov_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(recov_q) |-> $past(exec && evt_i.cmd == CMD_ENTER))
    else $error("recovery entered without enter event");
`endif

`ifndef ASSERT_OFF
  a_tx_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && evt_i.cmd == CMD_TX && err == ERR_NONE) |=> (inflight_q <= window_q))
    else $error("accepted send overran window");
`endif

`ifndef ASSERT_OFF
  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(exec))
    else $error("result appeared without execution");
`endif

endmodule

>>> sv/sctp_congestion_window.sv
// ----------------------------------------------------------------------------
// sctp_congestion_window
// Event-driven congestion window keeper with slow start, congestion avoidance,
// fast recovery halving and timeout handling.
// ----------------------------------------------------------------------------
// Each input item is one event (ack, transmit, enter or exit fast recovery,
// idle, retransmission timeout, restart, query) and yields exactly one result
// item carrying the window, slow start threshold, bytes in flight, recovery
// flag, stored exit sequence number, whether the item's byte count fit the
// window before the step, and an error code. Rejected events leave state
// untouched. The block sustains one item per clock while the result side is
// ready: the decoder feeds a two-entry event queue, and the execution stage
// updates all state registers and loads a result register together, so
// throughput is set by that update loop. An accepted item passes the queue
// and then the result register before result valid rises. The user must
// write path_mtu through cfg_we_i / cfg_wdata_i only while the block is idle;
// the block does not enforce this. path_mtu resets to 1500 and a restart
// event rebuilds the window from the current value.
// ----------------------------------------------------------------------------
module sctp_congestion_window (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scw_pkg::MtuBits-1:0]     cfg_wdata_i,    // path_mtu
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [19:0] byte_count, [20] ack_point_advanced, [21] data_pending,
  // [53:22] recovery_exit_tsn, [55:54] zero
  input  logic [scw_pkg::InDataBits-1:0]  s_axis_tdata,
  input  logic [scw_pkg::CmdBits-1:0]     s_axis_tuser,   // [2:0] command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] fits_window, [32:1] window_bytes, [64:33] threshold_bytes,
  // [96:65] outstanding_bytes, [97] recovering, [129:98] exit_tsn, [135:130] zero
  output logic [scw_pkg::OutDataBits-1:0] m_axis_tdata,
  output logic [scw_pkg::ErrBits-1:0]     m_axis_tuser    // [2:0] error_code
);
  import scw_pkg::*;

  logic [MtuBits-1:0] mtu_q;
  event_t             front_evt, queue_evt;
  logic               queue_full, queue_valid, queue_pop;

  // Path MTU register: hold until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= ResetMtu;
    end else if (cfg_we_i) begin
      mtu_q <= cfg_wdata_i;
    end
  end

  // Accept whenever the queue has room; the result register isolates the far side
  assign s_axis_tready = !queue_full;

  scw_front u_front (
    .cmd_i  (s_axis_tuser),
    .data_i (s_axis_tdata),
    .mtu_i  (mtu_q),
    .evt_o  (front_evt)
  );

  scw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid),
    .push_evt_i (front_evt),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .valid_o    (queue_valid),
    .pop_evt_o  (queue_evt)
  );

  scw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mtu_i       (mtu_q),
    .evt_valid_i (queue_valid),
    .evt_i       (queue_evt),
    .evt_pop_o   (queue_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser)
  );

endmodule
